// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while the block is out of reset.
`define SSFF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define SSFF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ssff_pkg.sv =====
package ssff_pkg;

  // Function codes of a display request.
  localparam logic [2:0] FUNC_NUMBER  = 3'd0;
  localparam logic [2:0] FUNC_TIME    = 3'd1;
  localparam logic [2:0] FUNC_DATE    = 3'd2;
  localparam logic [2:0] FUNC_YEAR    = 3'd3;
  localparam logic [2:0] FUNC_WEEKDAY = 3'd4;

  // Segment constants (active low, bit 7 is the dot).
  localparam logic [7:0] SEG_BLANK    = 8'hFF;
  localparam logic [7:0] SEG_DOT_MASK = 8'h7F;

  // Width of the number field and the reciprocal used to divide it by ten.
  localparam int          NUM_W       = 27;
  localparam int          RECIP_W     = 32;
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Payload of one display request.
  typedef struct packed {
    logic [2:0]  func;
    logic [26:0] number_value;
    logic [3:0]  pad_digits;
    logic        unit_dot;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [5:0]  seconds;
    logic [6:0]  month;
    logic [6:0]  day_of_month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_num;
    logic start_b;
    logic emit_week;
    logic last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic field_done;
    logic week_done;
  } dp_stat_t;

  // Segment code of one decimal digit.
  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] code;
    case (d)
      4'd0: code = 8'd192;
      4'd1: code = 8'd249;
      4'd2: code = 8'd164;
      4'd3: code = 8'd176;
      4'd4: code = 8'd153;
      4'd5: code = 8'd146;
      4'd6: code = 8'd131;
      4'd7: code = 8'd248;
      4'd8: code = 8'd128;
      4'd9: code = 8'd152;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  // Segment code of weekday character pos, sent right to left: the three
  // letters from the last one back, then a blank. Bad weekdays are blank.
  function automatic logic [7:0] week_seg(input logic [2:0] wd, input logic [1:0] pos);
    logic [23:0] name;
    logic        valid;
    logic [7:0]  code;
    valid = 1'b1;
    case (wd)
      3'd1: name = 24'h92C1C8;
      3'd2: name = 24'hEAC0C8;
      3'd3: name = 24'h87C186;
      3'd4: name = 24'hD586A1;
      3'd5: name = 24'h878BC1;
      3'd6: name = 24'h8ECCCF;
      3'd7: name = 24'h928887;
      default: begin
        name  = 24'hFFFFFF;
        valid = 1'b0;
      end
    endcase
    case (pos)
      2'd0: code = name[7:0];
      2'd1: code = name[15:8];
      2'd2: code = name[23:16];
      default: code = SEG_BLANK;
    endcase
    if (!valid) begin
      code = SEG_BLANK;
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/ssff_if.sv =====
// Request channel: one display request per handshake.
interface ssff_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [26:0] number_value;
  logic [3:0]  pad_digits;
  logic        unit_dot;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [5:0]  seconds;
  logic [6:0]  month;
  logic [6:0]  day_of_month;
  logic [13:0] year;
  logic [2:0]  weekday;

  modport source(
    output valid, func, number_value, pad_digits, unit_dot, hour, minute, seconds,
    output month, day_of_month, year, weekday,
    input  ready
  );
  modport sink(
    input  valid, func, number_value, pad_digits, unit_dot, hour, minute, seconds,
    input  month, day_of_month, year, weekday,
    output ready
  );
endinterface

// Result channel: one segment byte per handshake.
interface ssff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_code;
  logic       last;

  modport source(output valid, segment_code, last, input ready);
  modport sink(input valid, segment_code, last, output ready);
endinterface

// ===== hw/rtl/ssff_ctrl.sv =====
module ssff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_func,
  output logic               in_ready,
  input  ssff_pkg::dp_stat_t stat,
  output ssff_pkg::dp_cmd_t  ctl
);

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_NUM_ONLY   = 5'b00010,
    ST_NUM_FIRST  = 5'b00100,
    ST_NUM_SECOND = 5'b01000,
    ST_WEEK       = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          case (in_func)
            ssff_pkg::FUNC_NUMBER:  state_nxt = ST_NUM_ONLY;
            ssff_pkg::FUNC_YEAR:    state_nxt = ST_NUM_ONLY;
            ssff_pkg::FUNC_TIME:    state_nxt = ST_NUM_FIRST;
            ssff_pkg::FUNC_DATE:    state_nxt = ST_NUM_FIRST;
            ssff_pkg::FUNC_WEEKDAY: state_nxt = ST_WEEK;
            default:                state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NUM_ONLY, ST_NUM_SECOND: begin
        if (stat.out_free) begin
          ctl.emit_num = 1'b1;
          ctl.last     = stat.field_done;
          if (stat.field_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NUM_FIRST: begin
        if (stat.out_free) begin
          ctl.emit_num = 1'b1;
          if (stat.field_done) begin
            ctl.start_b = 1'b1;
            state_nxt   = ST_NUM_SECOND;
          end
        end
      end
      ST_WEEK: begin
        if (stat.out_free) begin
          ctl.emit_week = 1'b1;
          ctl.last      = stat.week_done;
          if (stat.week_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/ssff_dp.sv =====
module ssff_dp #(
  parameter int MAX_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssff_pkg::cmd_t     cmd_in,
  input  ssff_pkg::dp_cmd_t  ctl,
  output ssff_pkg::dp_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_code,
  output logic               out_last
);

  localparam int NUM_W  = ssff_pkg::NUM_W;
  localparam int PROD_W = NUM_W + ssff_pkg::RECIP_W;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

  // Field being printed: value, digits shown so far, pad target and dot.
  logic [NUM_W-1:0] val_r;
  logic [CNT_W-1:0] shown_r;
  logic [CNT_W-1:0] pad_r;
  logic             dot_r;
  // Second field of time and date requests.
  logic [6:0]       bval_r;
  logic             bdot_r;
  // Weekday and character position.
  logic [2:0]       wd_r;
  logic [1:0]       wpos_r;
  // Output register.
  logic             out_valid_r;
  logic [7:0]       out_code_r;
  logic             out_last_r;

  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  quot;
  logic [NUM_W-1:0]  rem_full;
  logic [7:0]        dig_code;
  logic [7:0]        week_code;
  logic [CNT_W-1:0]  shown_inc;
  logic              digit_more;
  logic              pad_more;
  logic              field_done;
  logic [CNT_W-1:0]  pad_ld;
  logic [13:0]       year_adj;
  logic [NUM_W-1:0]  ld_val;
  logic [CNT_W-1:0]  ld_pad;
  logic              ld_dot;
  logic [6:0]        ld_bval;
  logic              ld_bdot;

  // Divide by ten with a reciprocal multiply; exact for values below 2^32.
  assign prod     = {{ssff_pkg::RECIP_W{1'b0}}, val_r}
                  * {{NUM_W{1'b0}}, ssff_pkg::RECIP10};
  assign quot     = NUM_W'(prod[PROD_W-1:ssff_pkg::RECIP_SHIFT]);
  assign rem_full = val_r - ((quot << 3) + (quot << 1));

  // Digit code, with the dot on the units digit when asked for.
  always_comb begin
    dig_code = ssff_pkg::digit_seg(rem_full[3:0]);
    if (shown_r == '0 && dot_r) begin
      dig_code = dig_code & ssff_pkg::SEG_DOT_MASK;
    end
  end

  // The field ends when no digit is left to show and the pad count is met.
  assign shown_inc  = shown_r + CNT_W'(1);
  assign digit_more = (quot != '0) && (shown_inc < CNT_W'(MAX_DIGITS));
  assign pad_more   = shown_inc < pad_r;
  assign field_done = !digit_more && !pad_more;

  assign week_code = ssff_pkg::week_seg(wd_r, wpos_r);

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.field_done = field_done;
  assign stat.week_done  = (wpos_r == 2'd3);

  // Pad target clamped to the digit limit, and the year offset.
  assign pad_ld   = (int'(cmd_in.pad_digits) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS)
                                                           : CNT_W'(cmd_in.pad_digits);
  assign year_adj = (cmd_in.year < 14'd100) ? (cmd_in.year + 14'd2000) : cmd_in.year;

  // Field values taken when a request is loaded. Time is the default: minute
  // first, then the hour with its dot on even seconds.
  always_comb begin
    ld_val  = NUM_W'(cmd_in.minute);
    ld_pad  = CNT_W'(2);
    ld_dot  = 1'b0;
    ld_bval = cmd_in.hour;
    ld_bdot = !cmd_in.seconds[0];
    case (cmd_in.func)
      ssff_pkg::FUNC_NUMBER: begin
        ld_val = cmd_in.number_value;
        ld_pad = pad_ld;
        ld_dot = cmd_in.unit_dot;
      end
      ssff_pkg::FUNC_DATE: begin
        ld_val  = NUM_W'(cmd_in.day_of_month);
        ld_bval = cmd_in.month;
        ld_bdot = 1'b1;
      end
      ssff_pkg::FUNC_YEAR: begin
        ld_val = NUM_W'(year_adj);
        ld_pad = CNT_W'(4);
      end
      default: begin
      end
    endcase
  end

  // Field registers: load a request, switch to the second field, or step a digit.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shown_r <= '0;
      wd_r    <= cmd_in.weekday;
      wpos_r  <= 2'd0;
      bval_r  <= ld_bval;
      bdot_r  <= ld_bdot;
      val_r   <= ld_val;
      pad_r   <= ld_pad;
      dot_r   <= ld_dot;
    end else if (ctl.start_b) begin
      val_r   <= NUM_W'(bval_r);
      shown_r <= '0;
      pad_r   <= CNT_W'(2);
      dot_r   <= bdot_r;
    end else if (ctl.emit_num) begin
      val_r   <= digit_more ? quot : '0;
      shown_r <= shown_inc;
    end else if (ctl.emit_week) begin
      wpos_r <= wpos_r + 2'd1;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_num || ctl.emit_week) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (ctl.emit_num || ctl.emit_week) begin
      out_code_r <= ctl.emit_num ? dig_code : week_code;
      out_last_r <= ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/seven_segment_field_formatter_top.sv =====
// Seven-segment field formatter.
// in_cmd carries one display request (number, time, date, year or weekday);
// out_seg returns its active-low segment bytes one per handshake on that
// channel, least significant character first, with last set on the final one.
// A request is taken only while the block is idle. It is first loaded into the
// field registers; its bytes are then registered in the output register one per
// cycle while the receiver keeps ready high. The block stays busy until the
// final byte is registered; the digit loop does one divide by ten per byte.
// An unused function code is taken and produces no bytes.
// While the receiver holds ready low, the output register keeps its byte and
// the digit loop waits; no byte is lost or repeated.
// Reset (rst_n low at a clock edge) returns the controller to idle and empties
// the output register.
module seven_segment_field_formatter_top #(
  parameter int MAX_DIGITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  ssff_in_if.sink           in_cmd,
  ssff_out_if.source        out_seg
);

  ssff_pkg::cmd_t     cmd;
  ssff_pkg::dp_cmd_t  ctl;
  ssff_pkg::dp_stat_t stat;
  logic               in_ready;
  logic               out_valid;
  logic [7:0]         out_code;
  logic               out_last;

  // Gather the request fields.
  assign cmd.func         = in_cmd.func;
  assign cmd.number_value = in_cmd.number_value;
  assign cmd.pad_digits   = in_cmd.pad_digits;
  assign cmd.unit_dot     = in_cmd.unit_dot;
  assign cmd.hour         = in_cmd.hour;
  assign cmd.minute       = in_cmd.minute;
  assign cmd.seconds      = in_cmd.seconds;
  assign cmd.month        = in_cmd.month;
  assign cmd.day_of_month = in_cmd.day_of_month;
  assign cmd.year         = in_cmd.year;
  assign cmd.weekday      = in_cmd.weekday;

  ssff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_func  (in_cmd.func),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ssff_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (out_seg.ready),
    .out_valid (out_valid),
    .out_code  (out_code),
    .out_last  (out_last)
  );

  // Drive the channel signals.
  assign in_cmd.ready         = in_ready;
  assign out_seg.valid        = out_valid;
  assign out_seg.segment_code = out_code;
  assign out_seg.last         = out_last;

endmodule

// ===== hw/rtl/ssff_chk.sv =====
`include "assert_macros.svh"

module ssff_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_segment_code,
  input logic       out_last
);

  logic       out_stall;
  logic [8:0] out_word;
  logic       req_makes_bytes;

  // A byte waiting on the receiver, and the payload it shows.
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_segment_code, out_last};

  // An accepted request whose function code produces bytes.
  assign req_makes_bytes = in_valid && in_ready &&
                           (in_func == ssff_pkg::FUNC_NUMBER ||
                            in_func == ssff_pkg::FUNC_TIME ||
                            in_func == ssff_pkg::FUNC_DATE ||
                            in_func == ssff_pkg::FUNC_YEAR ||
                            in_func == ssff_pkg::FUNC_WEEKDAY);

  // A stalled byte keeps its value until taken.
  `SSFF_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_word))

  // Reset empties the output register.
  `SSFF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // A request that makes bytes keeps the block busy in the next cycle.
  `SSFF_ASSERT(a_busy_after_req, clk, rst_n, req_makes_bytes |=> !in_ready)

  // While a byte other than the final one is shown, no new request is taken.
  `SSFF_ASSERT(a_mid_stream_busy, clk, rst_n, out_valid && !out_last |-> !in_ready)

endmodule

bind seven_segment_field_formatter_top ssff_chk u_ssff_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_cmd.valid),
  .in_ready         (in_cmd.ready),
  .in_func          (in_cmd.func),
  .out_valid        (out_seg.valid),
  .out_ready        (out_seg.ready),
  .out_segment_code (out_seg.segment_code),
  .out_last         (out_seg.last)
);

// ===== verif/tb.sv =====
module tb;

  localparam int MAX_DIGITS  = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;

  // Active-low digit codes 0..9 and the weekday names, first letter in the top byte.
  localparam logic [7:0] DIGIT_SEGS [10] = '{8'd192, 8'd249, 8'd164, 8'd176, 8'd153,
                                             8'd146, 8'd131, 8'd248, 8'd128, 8'd152};
  localparam logic [23:0] WEEKDAY_NAMES [7] = '{24'h92C1C8, 24'hEAC0C8, 24'h87C186,
                                                24'hD586A1, 24'h878BC1, 24'h8ECCCF,
                                                24'h928887};

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } seg_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  ssff_in_if  in_cmd();
  ssff_out_if out_seg();

  seven_segment_field_formatter_top #(.MAX_DIGITS(MAX_DIGITS)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_cmd),
    .out_seg (out_seg)
  );

  seg_byte_t expected_segs[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        sink_wait = 0;
  int        taken_count = 0;
  int        seen_count = 0;
  bit        idle_on = 1'b1;
  bit        hold_go = 1'b0;
  bit        receiver_hold = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count a failure and show the first few of them.
  function automatic void log_mismatch(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // Decimal digits units first, optional units dot, then zero padding.
  function automatic void push_number(input int unsigned value, input int unsigned pad,
                                      input bit dot);
    int unsigned v;
    int unsigned shown;
    logic [7:0]  seg;
    v = value;
    shown = 0;
    if (pad > MAX_DIGITS) begin
      pad = MAX_DIGITS;
    end
    do begin
      seg = DIGIT_SEGS[v % 10];
      if (shown == 0 && dot) begin
        seg = seg & ssff_pkg::SEG_DOT_MASK;
      end
      expected_segs.push_back({seg, 1'b0});
      shown++;
      v = v / 10;
    end while (v > 0 && shown < MAX_DIGITS);
    while (shown < pad) begin
      expected_segs.push_back({DIGIT_SEGS[0], 1'b0});
      shown++;
    end
  endfunction

  // Append the bytes one request should produce and flag the final one.
  function automatic void predict_segments(input ssff_pkg::cmd_t c);
    int          first;
    int unsigned yr;
    logic [23:0] name;
    first = expected_segs.size();
    case (c.func)
      ssff_pkg::FUNC_NUMBER: push_number(c.number_value, c.pad_digits, c.unit_dot);
      ssff_pkg::FUNC_TIME: begin
        push_number(c.minute, 2, 1'b0);
        push_number(c.hour, 2, c.seconds[0] == 1'b0);
      end
      ssff_pkg::FUNC_DATE: begin
        push_number(c.day_of_month, 2, 1'b0);
        push_number(c.month, 2, 1'b1);
      end
      ssff_pkg::FUNC_YEAR: begin
        yr = c.year;
        if (yr < 100) begin
          yr = yr + 2000;
        end
        push_number(yr, 4, 1'b0);
      end
      ssff_pkg::FUNC_WEEKDAY: begin
        if (c.weekday != 3'd0) begin
          name = WEEKDAY_NAMES[c.weekday - 1];
          expected_segs.push_back({name[7:0], 1'b0});
          expected_segs.push_back({name[15:8], 1'b0});
          expected_segs.push_back({name[23:16], 1'b0});
          expected_segs.push_back({ssff_pkg::SEG_BLANK, 1'b0});
        end else begin
          repeat (4) expected_segs.push_back({ssff_pkg::SEG_BLANK, 1'b0});
        end
      end
      default: ;
    endcase
    if (expected_segs.size() > first) begin
      expected_segs[expected_segs.size() - 1].last = 1'b1;
    end
  endfunction

  // Offer one request, after a random gap while idling is on, and hold it until it is taken.
  task automatic send_cmd(input ssff_pkg::cmd_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_cmd.valid = 1'b0;
    end
    @(negedge clk);
    in_cmd.valid        = 1'b1;
    in_cmd.func         = c.func;
    in_cmd.number_value = c.number_value;
    in_cmd.pad_digits   = c.pad_digits;
    in_cmd.unit_dot     = c.unit_dot;
    in_cmd.hour         = c.hour;
    in_cmd.minute       = c.minute;
    in_cmd.seconds      = c.seconds;
    in_cmd.month        = c.month;
    in_cmd.day_of_month = c.day_of_month;
    in_cmd.year         = c.year;
    in_cmd.weekday      = c.weekday;
    do @(posedge clk); while (!in_cmd.ready);
    predict_segments(c);
  endtask

  function automatic ssff_pkg::cmd_t number_cmd(input int unsigned value,
                                                input int unsigned pad, input bit dot);
    ssff_pkg::cmd_t c;
    c = '0;
    c.func         = ssff_pkg::FUNC_NUMBER;
    c.number_value = 27'(value);
    c.pad_digits   = 4'(pad);
    c.unit_dot     = dot;
    return c;
  endfunction

  // Random request: mostly valid functions, fields usually in range, sometimes full width.
  function automatic ssff_pkg::cmd_t random_cmd();
    ssff_pkg::cmd_t c;
    logic [95:0]    raw;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(ssff_pkg::cmd_t)-1:0];
    if ($urandom_range(0, 19) != 0) begin
      c.func = 3'($urandom_range(0, 4));
    end else begin
      c.func = ssff_pkg::FUNC_WEEKDAY + 3'($urandom_range(1, 3));
    end
    case ($urandom_range(0, 3))
      0: c.number_value = 27'($urandom_range(0, 9));
      1: c.number_value = 27'($urandom_range(0, 9999));
      2: c.number_value = 27'($urandom_range(0, 99999999));
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      c.hour         = 7'($urandom_range(0, 99));
      c.minute       = 7'($urandom_range(0, 99));
      c.seconds      = 6'($urandom_range(0, 59));
      c.month        = 7'($urandom_range(0, 99));
      c.day_of_month = 7'($urandom_range(0, 99));
      c.year         = 14'($urandom_range(0, 9999));
      c.pad_digits   = 4'($urandom_range(0, 8));
    end
    return c;
  endfunction

  // Number mode: zero, largest values, overlong values, padding and the units dot.
  task automatic test_number_extremes();
    send_cmd(number_cmd(0, 0, 1'b0));
    send_cmd(number_cmd(0, 8, 1'b1));
    send_cmd(number_cmd(99999999, 0, 1'b1));
    send_cmd(number_cmd(27'h7FF_FFFF, 15, 1'b0));
    send_cmd(number_cmd(5, 3, 1'b1));
  endtask

  // Time and date: both dot rules and the full width of each field.
  task automatic test_time_and_date();
    ssff_pkg::cmd_t c;
    c = '0;
    c.func = ssff_pkg::FUNC_TIME;
    send_cmd(c);
    c.hour = 7'd99;
    c.minute = 7'd99;
    c.seconds = 6'd59;
    send_cmd(c);
    c.hour = 7'h7F;
    c.minute = 7'h7F;
    c.seconds = 6'h3F;
    send_cmd(c);
    c = '0;
    c.func = ssff_pkg::FUNC_DATE;
    send_cmd(c);
    c.month = 7'h7F;
    c.day_of_month = 7'h7F;
    send_cmd(c);
  endtask

  // Year: the 2000 offset at its boundary and the widest value.
  task automatic test_year();
    ssff_pkg::cmd_t c;
    c = '0;
    c.func = ssff_pkg::FUNC_YEAR;
    c.year = 14'd99;
    send_cmd(c);
    c.year = 14'd100;
    send_cmd(c);
    c.year = 14'h3FFF;
    send_cmd(c);
  endtask

  // Every weekday code, including the out-of-range one.
  task automatic test_weekdays();
    ssff_pkg::cmd_t c;
    c = '0;
    c.func = ssff_pkg::FUNC_WEEKDAY;
    for (int wd = 0; wd < 8; wd++) begin
      c.weekday = 3'(wd);
      send_cmd(c);
    end
  endtask

  // Function codes past weekday produce nothing.
  task automatic test_unused_funcs();
    ssff_pkg::cmd_t c;
    c = '0;
    for (int k = 1; k <= 3; k++) begin
      c.func = ssff_pkg::FUNC_WEEKDAY + 3'(k);
      send_cmd(c);
    end
  endtask

  task automatic test_random_mix(input int count);
    idle_on = 1'b1;
    repeat (count) send_cmd(random_cmd());
  endtask

  // No idling on either side, so bytes and requests run back to back.
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_cmd(random_cmd());
    idle_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_receiver_hold(input int count);
    idle_on = 1'b0;
    hold_go = 1'b1;
    repeat (count) send_cmd(random_cmd());
    hold_go = 1'b0;
    idle_on = 1'b1;
  endtask

  // Long receiver stall, counted on the rising edge.
  always begin
    @(posedge hold_go);
    @(posedge clk);
    receiver_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold = 1'b0;
  end

  // Receiver: ready drops for the drawn stall after each byte and during a hold.
  always @(negedge clk) begin
    if (taken_count != seen_count) begin
      seen_count = taken_count;
      sink_wait = idle_on ? $urandom_range(0, 5) : 0;
    end
    if (receiver_hold) begin
      out_seg.ready = 1'b0;
    end else if (sink_wait > 0) begin
      out_seg.ready = 1'b0;
      sink_wait--;
    end else begin
      out_seg.ready = 1'b1;
    end
  end

  // Compare each byte taken with the oldest prediction.
  always @(posedge clk) begin
    seg_byte_t want;
    if (rst_n === 1'b1 && out_seg.valid === 1'b1 && out_seg.ready === 1'b1) begin
      if (expected_segs.size() == 0) begin
        log_mismatch($sformatf("unexpected byte %h last %b", out_seg.segment_code,
                               out_seg.last));
      end else begin
        want = expected_segs.pop_front();
        if (want.code !== out_seg.segment_code || want.last !== out_seg.last) begin
          log_mismatch($sformatf("expected code %h last %b, got code %h last %b",
                                 want.code, want.last, out_seg.segment_code,
                                 out_seg.last));
        end
      end
      taken_count++;
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("seven_segment_field_formatter_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_cmd.valid = 1'b0;
    in_cmd.func = ssff_pkg::FUNC_NUMBER;
    in_cmd.number_value = '0;
    in_cmd.pad_digits = '0;
    in_cmd.unit_dot = 1'b0;
    in_cmd.hour = '0;
    in_cmd.minute = '0;
    in_cmd.seconds = '0;
    in_cmd.month = '0;
    in_cmd.day_of_month = '0;
    in_cmd.year = '0;
    in_cmd.weekday = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_number_extremes();
    test_time_and_date();
    test_year();
    test_weekdays();
    test_unused_funcs();
    test_random_mix(150);
    test_back_to_back(80);
    test_receiver_hold(30);
    test_random_mix(100);

    @(negedge clk);
    in_cmd.valid = 1'b0;
    while (expected_segs.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("seven_segment_field_formatter_top regression: pass");
    end else begin
      $display("seven_segment_field_formatter_top regression: fail");
    end
    $finish;
  end

endmodule
